/* rtl/scc_pkg.sv */
// Package with the types, codes and CRC function of the scratchpad checker.
`timescale 1ns / 1ps

package scc_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int COUNT_W = 4;
  localparam logic [COUNT_W-1:0] FRAME_LAST = COUNT_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic OP_PRESENCE = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NODEV = 2'd1;
  localparam logic [1:0] ST_CRCERR = 2'd2;

  typedef struct packed {
    logic       operation;
    logic       present;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       feed;
    c = crc;
    for (int b = 0; b < 8; b++) begin
      feed = c[0] ^ data[b];
      c = {1'b0, c[7:1]};
      if (feed) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/scc_if.sv */
// Valid/ready channel interfaces for input items and result words.
`timescale 1ns / 1ps

interface scc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       present;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output present, output data_byte,
                  input ready);
  modport sink (input valid, input operation, input present, input data_byte,
                output ready);
endinterface

interface scc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] temperature;

  modport source (output valid, output status, output temperature, input ready);
  modport sink (input valid, input status, input temperature, output ready);
endinterface

/* rtl/scc_in_stage.sv */
// Input register stage that holds one accepted item for the checker core.
`timescale 1ns / 1ps

module scc_in_stage
  import scc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  scc_in_if.sink       item_in,
  input  logic         take,
  output stage_t       stage
);

  logic  held_valid;
  item_t held_item;

  assign item_in.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_in.ready) begin
      held_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      held_item.operation <= item_in.operation;
      held_item.present <= item_in.present;
      held_item.data_byte <= item_in.data_byte;
    end
  end

  assign stage.valid = held_valid;
  assign stage.item = held_item;

endmodule

/* rtl/scc_core.sv */
// Frame tracking, CRC update and result register of the scratchpad checker.
`timescale 1ns / 1ps

module scc_core
  import scc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  stage_t       stage,
  output logic         take,
  scc_out_if.source    result_out
);

  logic               frame_active;
  logic               frame_active_next;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [7:0]         crc_accumulator;
  logic [7:0]         crc_accumulator_next;
  logic [7:0]         temp_low_byte;
  logic [7:0]         temp_high_byte;
  logic               has_result;
  logic [1:0]         res_status;
  logic [15:0]        res_temp;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [15:0]        out_temp;

  always_comb begin
    frame_active_next = frame_active;
    byte_count_next = byte_count;
    crc_accumulator_next = crc_accumulator;
    has_result = 1'b0;
    res_status = ST_OK;
    res_temp = 16'd0;
    if (stage.item.operation == OP_PRESENCE) begin
      if (!stage.item.present) begin
        frame_active_next = 1'b0;
        has_result = 1'b1;
        res_status = ST_NODEV;
      end else begin
        frame_active_next = 1'b1;
        byte_count_next = '0;
        crc_accumulator_next = 8'd0;
      end
    end else if (frame_active) begin
      if (byte_count < FRAME_LAST) begin
        crc_accumulator_next = crc8_update(crc_accumulator, stage.item.data_byte);
        byte_count_next = byte_count + COUNT_W'(1);
      end else begin
        frame_active_next = 1'b0;
        has_result = 1'b1;
        if (crc_accumulator == stage.item.data_byte) begin
          res_status = ST_OK;
          res_temp = {temp_high_byte, temp_low_byte};
        end else begin
          res_status = ST_CRCERR;
        end
      end
    end
  end

  assign take = stage.valid && (!out_valid || result_out.ready || !has_result);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      byte_count <= '0;
      crc_accumulator <= 8'd0;
    end else if (take) begin
      frame_active <= frame_active_next;
      byte_count <= byte_count_next;
      crc_accumulator <= crc_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage.item.operation == OP_BYTE && frame_active) begin
      if (byte_count == COUNT_W'(0)) begin
        temp_low_byte <= stage.item.data_byte;
      end else if (byte_count == COUNT_W'(1)) begin
        temp_high_byte <= stage.item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && has_result) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_result) begin
      out_status <= res_status;
      out_temp <= res_temp;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.status = out_status;
  assign result_out.temperature = $signed(out_temp);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= FRAME_LAST)
    else $error("byte count ran past the last frame byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_out.ready) |-> !(take && has_result))
    else $error("pending result word overwritten");

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    (take && has_result) |=> out_valid)
    else $error("result word not presented");

  a_idle_byte: assert property (@(posedge clk) disable iff (rst)
    (take && stage.item.operation == OP_BYTE && !frame_active)
      |=> ($stable(byte_count) && $stable(crc_accumulator) && !frame_active))
    else $error("byte outside a frame changed state");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> out_temp == 16'd0)
    else $error("failed result carries a temperature");

endmodule

/* rtl/scratchpad_crc_temperature_checker.sv */
// Top level of the scratchpad CRC and temperature checker.
//
//   channel     dir  fields                          word
//   item_in     in   operation, present, data_byte   presence report or scratchpad byte
//   result_out  out  status, temperature             no-device, ok or CRC-error result
//
// Each word is registered at the input, and one CRC byte update and compare then feed
// the result register, so a new word is taken in every cycle unless a stalled result
// word holds back a word that produces a result.
// Reset is synchronous and clears the frame state, the CRC and both valid flags.
// A stalled result word holds; words that produce no result keep flowing behind it.
`timescale 1ns / 1ps

module scratchpad_crc_temperature_checker
  import scc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  scc_in_if.sink    item_in,
  scc_out_if.source result_out
);

  stage_t stage;
  logic   take;

  scc_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .take    (take),
    .stage   (stage)
  );

  scc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .take       (take),
    .result_out (result_out)
  );

endmodule
